// ----- sv/etfp_pkg.sv -----
// package: payload types, number format and register map of the fractal pixel block
package etfp_pkg;

  // number format of every coordinate: signed, 32 bits, FracBits fraction bits
  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracBits = 28;

  // register map, indexed by paddr[2]
  localparam logic RegJuliaCRe = 1'b0;
  localparam logic RegJuliaCIm = 1'b1;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // reset values of the julia constant (about -0.7 + 0.27i)
  localparam logic signed [CoordW-1:0] JuliaCReRst = -32'sd187904819;
  localparam logic signed [CoordW-1:0] JuliaCImRst = 32'sd72477573;

  // input item
  typedef struct packed {
    logic                     mode;
    logic signed [CoordW-1:0] point_re;
    logic signed [CoordW-1:0] point_im;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] iterations;
    logic [2:0] band;
  } out_item_t;

  // mode codes
  localparam logic ModeJulia      = 1'b0;
  localparam logic ModeMandelbrot = 1'b1;

endpackage

// ----- sv/etfp_zsq.sv -----
// complex square-and-add unit: one z = z*z + c step plus the escape test on z
module etfp_zsq (
  input  logic signed [etfp_pkg::CoordW-1:0] z_re_i,
  input  logic signed [etfp_pkg::CoordW-1:0] z_im_i,
  input  logic signed [etfp_pkg::CoordW-1:0] c_re_i,
  input  logic signed [etfp_pkg::CoordW-1:0] c_im_i,
  output logic signed [etfp_pkg::CoordW-1:0] z_re_o,
  output logic signed [etfp_pkg::CoordW-1:0] z_im_o,
  output logic                               escape_o
);

  localparam int unsigned ProdW    = 2 * etfp_pkg::CoordW;
  localparam int unsigned EscShift = 2 * etfp_pkg::FracBits + 2;
  localparam bit          EscReach = (EscShift < ProdW);
  localparam logic [ProdW-1:0] EscLimit =
    EscReach ? (ProdW'(1) << EscShift) : '0;

  function automatic logic signed [etfp_pkg::CoordW-1:0] sat_coord(
    input logic signed [ProdW-1:0] v
  );
    logic signed [ProdW-1:0] max_v;
    logic signed [ProdW-1:0] min_v;
    max_v = ProdW'({1'b0, {(etfp_pkg::CoordW-1){1'b1}}});
    min_v = -max_v - ProdW'(1);
    if (v > max_v) begin
      return max_v[etfp_pkg::CoordW-1:0];
    end else if (v < min_v) begin
      return min_v[etfp_pkg::CoordW-1:0];
    end
    return v[etfp_pkg::CoordW-1:0];
  endfunction

  logic signed [ProdW-1:0] re_sq;
  logic signed [ProdW-1:0] im_sq;
  logic signed [ProdW-1:0] re_im;
  logic signed [ProdW-1:0] re_sum;
  logic signed [ProdW-1:0] im_sum;
  logic        [ProdW-1:0] mag_sq;

  // three products of the current z
  assign re_sq = ProdW'(z_re_i) * ProdW'(z_re_i);
  assign im_sq = ProdW'(z_im_i) * ProdW'(z_im_i);
  assign re_im = ProdW'(z_re_i) * ProdW'(z_im_i);

  // floor shifts back to the coordinate format, then add c
  assign re_sum = ((re_sq - im_sq) >>> etfp_pkg::FracBits) + ProdW'(c_re_i);
  assign im_sum = (re_im >>> (etfp_pkg::FracBits - 1)) + ProdW'(c_im_i);

  assign z_re_o = sat_coord(re_sum);
  assign z_im_o = sat_coord(im_sum);

  // exact |z|^2 > 4, both squares are nonnegative so the sum fits unsigned
  assign mag_sq   = $unsigned(re_sq) + $unsigned(im_sq);
  assign escape_o = EscReach && (mag_sq > EscLimit);

endmodule

// ----- sv/escape_time_fractal_pixel_top.sv -----
// top level: escape-time iteration engine for one mandelbrot or julia pixel
//
// Each input transfer carries one point of the complex plane and a mode bit.
// In julia mode z starts at the point and c is the julia constant held in the
// two configuration registers; in mandelbrot mode z starts at zero and c is
// the point. A single complex square-and-add unit runs one step of
// z = z*z + c per clock, and the same cycle that computes a step also tests
// |z|^2 > 4 on the z produced by the previous step. An item runs until it
// escapes or reaches MaxIterations steps; that loop through the
// square-and-add unit sets the rate. The block takes one item at a time:
// in_ready_o is high only while the engine is idle. The result (step count
// and a 0..7 color band) sits in an output register, so the next item is
// accepted while the previous result still waits for its transfer.
// Coordinates are signed Q4.28; sums that leave the 32-bit range saturate
// and iteration goes on. The julia constant lives at byte address 0 (real
// part) and 4 (imaginary part) of the apb port and should be written only
// while the block is idle.
module escape_time_fractal_pixel_top #(
  parameter int unsigned MaxIterations = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  etfp_pkg::in_item_t           in_data_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output etfp_pkg::out_item_t          out_data_o,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [etfp_pkg::AddrW-1:0]   paddr,
  input  logic [etfp_pkg::DataW-1:0]   pwdata,
  output logic [etfp_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  // step counter must hold MaxIterations itself
  localparam int unsigned CntW    = $clog2(MaxIterations + 1);
  // band thresholds are compared at a common scale of 1200 * count
  localparam int unsigned ScaledW = CntW + 11;

  // sequencer codes
  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                               state_q, state_d;
  logic [CntW-1:0]                    cnt_q, cnt_d;
  logic signed [etfp_pkg::CoordW-1:0] z_re_q, z_re_d;
  logic signed [etfp_pkg::CoordW-1:0] z_im_q, z_im_d;
  logic signed [etfp_pkg::CoordW-1:0] c_re_q, c_re_d;
  logic signed [etfp_pkg::CoordW-1:0] c_im_q, c_im_d;
  logic signed [etfp_pkg::CoordW-1:0] julia_re_q;
  logic signed [etfp_pkg::CoordW-1:0] julia_im_q;
  logic                               out_valid_q, out_valid_d;
  etfp_pkg::out_item_t                out_q, out_d;

  logic signed [etfp_pkg::CoordW-1:0] z_re_nxt;
  logic signed [etfp_pkg::CoordW-1:0] z_im_nxt;
  logic                               escape;
  logic                               in_xfer;
  logic                               out_free;
  logic                               esc_hit;
  logic                               max_hit;
  logic [CntW-1:0]                    res_cnt;
  logic [ScaledW-1:0]                 scaled;
  logic [2:0]                         band;
  logic                               cfg_wr;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      julia_re_q <= etfp_pkg::JuliaCReRst;
      julia_im_q <= etfp_pkg::JuliaCImRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        etfp_pkg::RegJuliaCRe: julia_re_q <= pwdata;
        etfp_pkg::RegJuliaCIm: julia_im_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      etfp_pkg::RegJuliaCRe: prdata = julia_re_q;
      etfp_pkg::RegJuliaCIm: prdata = julia_im_q;
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // shared square-and-add unit, fed from the z register every run cycle
  // ---------------------------------------------------------------------
  etfp_zsq u_zsq (
    .z_re_i   (z_re_q),
    .z_im_i   (z_im_q),
    .c_re_i   (c_re_q),
    .c_im_i   (c_im_q),
    .z_re_o   (z_re_nxt),
    .z_im_o   (z_im_nxt),
    .escape_o (escape)
  );

  // ---------------------------------------------------------------------
  // termination and result
  // ---------------------------------------------------------------------
  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  // output register can take a new result this cycle
  assign out_free   = !out_valid_q || out_ready_i;

  // z_q holds the result of step cnt_q-1 once cnt_q is nonzero
  assign esc_hit = (cnt_q != '0) && escape;
  assign max_hit = (cnt_q == CntW'(MaxIterations));
  assign res_cnt = esc_hit ? (cnt_q - CntW'(1)) : cnt_q;

  // color band: inside, background below 7 percent, else rounded gradient
  assign scaled = ScaledW'(res_cnt) * ScaledW'(1200);

  always_comb begin
    band = 3'd1;
    if (res_cnt >= CntW'(MaxIterations)) begin
      band = 3'd7;
    end else if (scaled < ScaledW'(84 * MaxIterations)) begin
      band = 3'd0;
    end else begin
      for (int b = 1; b <= 5; b++) begin
        if (scaled >= ScaledW'((186 * b - 9) * MaxIterations)) begin
          band = band + 3'd1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    z_re_d      = z_re_q;
    z_im_d      = z_im_q;
    c_re_d      = c_re_q;
    c_im_d      = c_im_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StRun;
          cnt_d   = '0;
          if (in_data_i.mode == etfp_pkg::ModeMandelbrot) begin
            z_re_d = '0;
            z_im_d = '0;
            c_re_d = in_data_i.point_re;
            c_im_d = in_data_i.point_im;
          end else begin
            z_re_d = in_data_i.point_re;
            z_im_d = in_data_i.point_im;
            c_re_d = julia_re_q;
            c_im_d = julia_im_q;
          end
        end
      end
      StRun: begin
        if (esc_hit || max_hit) begin
          // hold here until the output register is free
          if (out_free) begin
            out_valid_d      = 1'b1;
            out_d.iterations = 8'(res_cnt);
            out_d.band       = band;
            state_d          = StIdle;
          end
        end else begin
          z_re_d = z_re_nxt;
          z_im_d = z_im_nxt;
          cnt_d  = cnt_q + CntW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    z_re_q <= z_re_d;
    z_im_q <= z_im_d;
    c_re_q <= c_re_d;
    c_im_q <= c_im_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- bench/testbench.sv -----
// testbench: self-checking bench for the escape-time fractal pixel block
`timescale 1ns / 100ps

module testbench;
  import etfp_pkg::*;

  localparam int unsigned MaxIter    = 128;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned HoldAfter  = 200;
  localparam int unsigned SegItems   = 155;

  // 1.0 in q4.28 and the coordinate extremes
  localparam real                     QOne     = 268435456.0;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam longint                   SatHi    = 64'sh0000_0000_7FFF_FFFF;
  localparam longint                   SatLo    = -64'sh0000_0000_8000_0000;
  // |z|^2 bound: 4.0 at twice the fraction width
  localparam longint unsigned          EscapeBound = 64'd4 << (2 * FracBits);

  // register byte addresses
  localparam logic [AddrW-1:0] AddrJuliaCRe = {RegJuliaCRe, 2'b00};
  localparam logic [AddrW-1:0] AddrJuliaCIm = {RegJuliaCIm, 2'b00};

  typedef struct {
    in_item_t  point;
    out_item_t pixel;
  } pixel_entry_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [AddrW-1:0]     paddr     = '0;
  logic [DataW-1:0]     pwdata    = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  // local copy of the julia constant, kept in step with every register write
  logic signed [CoordW-1:0] julia_re = JuliaCReRst;
  logic signed [CoordW-1:0] julia_im = JuliaCImRst;

  in_item_t     queued_points[$];
  pixel_entry_t pending_pixels[$];

  int unsigned idle_phase   = 0;
  int unsigned mismatches   = 0;
  int unsigned points_in    = 0;
  int unsigned julia_points = 0;
  int unsigned results_out  = 0;
  int unsigned constants    = 1;
  int unsigned cycle_count  = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  logic [7:0]  bands_seen   = '0;

  escape_time_fractal_pixel_top #(
    .MaxIterations(MaxIter)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // escape count and color band of one point, iterating z = z*z + c in
  // q4.28 with floor shifts, saturated sums and an exact |z|^2 > 4 test
  function automatic out_item_t escape_time_of(input in_item_t pt,
                                               input logic signed [CoordW-1:0] c_re,
                                               input logic signed [CoordW-1:0] c_im);
    longint          zr, zi, kr, ki, nr, ni;
    longint unsigned mag;
    int unsigned     steps;
    int unsigned     b;
    out_item_t       res;
    if (pt.mode == ModeMandelbrot) begin
      zr = 0;
      zi = 0;
      kr = longint'($signed(pt.point_re));
      ki = longint'($signed(pt.point_im));
    end else begin
      zr = longint'($signed(pt.point_re));
      zi = longint'($signed(pt.point_im));
      kr = longint'(c_re);
      ki = longint'(c_im);
    end
    steps = MaxIter;
    for (int unsigned n = 0; n < MaxIter; n++) begin
      nr = ((zr * zr - zi * zi) >>> FracBits) + kr;
      ni = ((zr * zi) >>> (FracBits - 1)) + ki;
      zr = (nr > SatHi) ? SatHi : (nr < SatLo) ? SatLo : nr;
      zi = (ni > SatHi) ? SatHi : (ni < SatLo) ? SatLo : ni;
      mag = $unsigned(zr * zr) + $unsigned(zi * zi);
      if (mag > EscapeBound) begin
        steps = n;
        break;
      end
    end
    // one plus the round-half-up of 6*(it/M - 0.07)/0.93, done in integers
    if (steps >= MaxIter) begin
      b = 7;
    end else if (steps * 100 < 7 * MaxIter) begin
      b = 0;
    end else begin
      b = 1 + (12 * (steps * 100 - 7 * MaxIter) + 93 * MaxIter) / (186 * MaxIter);
      if (b < 1) b = 1;
      if (b > 6) b = 6;
    end
    res.iterations = steps[7:0];
    res.band       = b[2:0];
    return res;
  endfunction

  function automatic logic signed [CoordW-1:0] to_q(input real x);
    return $rtoi(x * QOne);
  endfunction

  // idle percentages per phase: sender light / receiver heavy, swapped, none
  function automatic int unsigned tx_idle_pct(input int unsigned ph);
    case (ph)
      0:       return 22;
      1:       return 50;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned rx_idle_pct(input int unsigned ph);
    case (ph)
      0:       return 50;
      1:       return 22;
      default: return 0;
    endcase
  endfunction

  // points near the set boundary, where the escape count is large but finite
  function automatic in_item_t boundary_point();
    in_item_t p;
    logic signed [CoordW-1:0] base_re, base_im;
    case ($urandom_range(0, 5))
      0:       begin base_re = to_q(-0.75); base_im = to_q(0.1);  end
      1:       begin base_re = to_q(0.25);  base_im = to_q(0.0);  end
      2:       begin base_re = to_q(-1.25); base_im = to_q(0.02); end
      3:       begin base_re = to_q(-0.1);  base_im = to_q(0.65); end
      4:       begin base_re = to_q(0.3);   base_im = to_q(0.5);  end
      default: begin base_re = to_q(-0.16); base_im = to_q(1.04); end
    endcase
    p.mode     = ModeMandelbrot;
    p.point_re = base_re + $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    p.point_im = base_im + $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    return p;
  endfunction

  function automatic logic signed [CoordW-1:0] special_coord();
    case ($urandom_range(0, 6))
      0:       return CoordMax;
      1:       return CoordMin;
      2:       return '0;
      3:       return 32'sd1;
      4:       return -32'sd1;
      5:       return to_q(2.0);
      default: return to_q(-2.0);
    endcase
  endfunction

  // mostly well-formed points in the interesting regions, some full-range noise
  function automatic in_item_t random_point();
    in_item_t    p;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      p.mode     = ModeMandelbrot;
      p.point_re = -32'sd536870912 + $urandom_range(0, 671088640);
      p.point_im = -32'sd335544320 + $urandom_range(0, 671088640);
    end else if (kind < 60) begin
      p = boundary_point();
    end else if (kind < 85) begin
      p.mode     = ModeJulia;
      p.point_re = -32'sd536870912 + $urandom_range(0, 32'h4000_0000);
      p.point_im = -32'sd536870912 + $urandom_range(0, 32'h4000_0000);
    end else if (kind < 95) begin
      p.mode     = 1'($urandom_range(0, 1));
      p.point_re = $urandom;
      p.point_im = $urandom;
    end else begin
      p.mode     = 1'($urandom_range(0, 1));
      p.point_re = special_coord();
      p.point_im = special_coord();
    end
    return p;
  endfunction

  task automatic add_point(input logic mode, input logic signed [CoordW-1:0] re,
                           input logic signed [CoordW-1:0] im);
    in_item_t p;
    p.mode     = mode;
    p.point_re = re;
    p.point_im = im;
    queued_points.push_back(p);
  endtask

  // one apb transfer: setup, then access; write and read data at the access edge
  task automatic apb_transfer(input logic wr, input logic [AddrW-1:0] addr,
                              input logic [DataW-1:0] wdata,
                              output logic [DataW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // read both halves of the julia constant back and compare with the local copy
  task automatic check_julia_regs();
    logic [DataW-1:0] rd;
    apb_transfer(1'b0, AddrJuliaCRe, '0, rd);
    if (rd !== julia_re) begin
      mismatches++;
      $display("%0t: julia_c_re readback expected %h got %h", $time, julia_re, rd);
    end
    apb_transfer(1'b0, AddrJuliaCIm, '0, rd);
    if (rd !== julia_im) begin
      mismatches++;
      $display("%0t: julia_c_im readback expected %h got %h", $time, julia_im, rd);
    end
  endtask

  task automatic load_julia_constant(input logic signed [CoordW-1:0] re,
                                     input logic signed [CoordW-1:0] im);
    logic [DataW-1:0] rd;
    apb_transfer(1'b1, AddrJuliaCRe, re, rd);
    apb_transfer(1'b1, AddrJuliaCIm, im, rd);
    julia_re = re;
    julia_im = im;
    constants++;
    check_julia_regs();
  endtask

  // sender pause: nothing queued, nothing offered, every result back
  task automatic wait_drained();
    while (queued_points.size() != 0 || in_valid || pending_pixels.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver: offers queued points, records the escape result of each transfer
  always @(posedge clk or negedge rst_n) begin : drive_points
    pixel_entry_t ent;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        ent.point = in_data;
        ent.pixel = escape_time_of(in_data, julia_re, julia_im);
        pending_pixels.push_back(ent);
        points_in++;
        if (in_data.mode == ModeJulia) julia_points++;
      end
      // a held valid stays up with its payload until the transfer happens
      if (!in_valid || in_ready) begin
        if (queued_points.size() != 0 &&
            $urandom_range(0, 99) >= tx_idle_pct(idle_phase)) begin
          in_data  <= queued_points.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest pending pixel,
  // and once holds ready low long enough for the block to back up
  always @(posedge clk or negedge rst_n) begin : check_pixels
    pixel_entry_t ent;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_out++;
        bands_seen[out_data.band] <= 1'b1;
        if (pending_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing pending, got iterations %0d band %0d",
                   $time, out_data.iterations, out_data.band);
        end else begin
          ent = pending_pixels.pop_front();
          if (out_data.iterations !== ent.pixel.iterations) begin
            mismatches++;
            $display("%0t: iterations expected %0d got %0d (mode %0d point %h %h)",
                     $time, ent.pixel.iterations, out_data.iterations,
                     ent.point.mode, ent.point.point_re, ent.point.point_im);
          end
          if (out_data.band !== ent.pixel.band) begin
            mismatches++;
            $display("%0t: band expected %0d got %0d (mode %0d point %h %h)",
                     $time, ent.pixel.band, out_data.band,
                     ent.point.mode, ent.point.point_re, ent.point.point_im);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && results_out >= HoldAfter) begin
        // long receiver stall while the sender keeps offering
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct(idle_phase));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d pixels still pending",
               cycle_count, pending_pixels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of the julia constant
    check_julia_regs();

    // directed points under the reset julia constant
    add_point(ModeMandelbrot, '0, '0);                    // origin, never escapes
    add_point(ModeMandelbrot, to_q(-2.0), '0);            // sits on |z|^2 == 4
    add_point(ModeMandelbrot, to_q(2.0), '0);             // equal to 4 then escapes
    add_point(ModeMandelbrot, '0, to_q(2.0));
    add_point(ModeMandelbrot, CoordMax, CoordMax);        // coordinate extremes
    add_point(ModeMandelbrot, CoordMin, CoordMin);
    add_point(ModeMandelbrot, CoordMax, CoordMin);
    add_point(ModeMandelbrot, CoordMin, CoordMax);
    add_point(ModeJulia, CoordMax, CoordMax);             // square saturates
    add_point(ModeJulia, CoordMin, CoordMin);
    add_point(ModeJulia, CoordMax, '0);
    add_point(ModeJulia, '0, CoordMin);
    add_point(ModeJulia, '0, '0);
    add_point(ModeMandelbrot, 32'sd1, -32'sd1);           // one lsb
    add_point(ModeJulia, -32'sd1, 32'sd1);
    add_point(ModeMandelbrot, to_q(0.26), '0);            // slow escapes, mid bands
    add_point(ModeMandelbrot, to_q(-0.75), to_q(0.05));
    add_point(ModeMandelbrot, to_q(0.2501), '0);
    add_point(ModeMandelbrot, to_q(-1.25), '0);           // inside, period two
    add_point(ModeMandelbrot, to_q(0.3), to_q(0.5));
    add_point(ModeMandelbrot, to_q(-0.16), to_q(1.04));
    add_point(ModeJulia, to_q(0.5), to_q(0.5));

    // random segments, each under its own julia constant, two segments per idle phase
    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      case (seg)
        0:       load_julia_constant(to_q(-0.8), to_q(0.156));
        1:       load_julia_constant(CoordMax, CoordMax);
        2:       load_julia_constant(CoordMin, CoordMin);
        3:       load_julia_constant(to_q(0.285), to_q(0.01));
        4:       load_julia_constant($urandom, $urandom);
        default: load_julia_constant('0, '0);
      endcase
      idle_phase = seg / 2;
      repeat (SegItems) queued_points.push_back(random_point());
    end

    // drain, then give the engine a full iteration run to show stray results
    while (queued_points.size() != 0 || in_valid || pending_pixels.size() != 0)
      @(posedge clk);
    repeat (2 * MaxIter) @(posedge clk);

    $display("covered %0d points (%0d julia, %0d mandelbrot) under %0d julia constants",
             points_in, julia_points, points_in - julia_points, constants);
    $display("checked %0d results, color bands seen %b, one receiver hold of %0d cycles",
             results_out, bands_seen, HoldCycles);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- escape_time_fractal_pixel_top.f -----
sv/etfp_pkg.sv
sv/etfp_zsq.sv
sv/escape_time_fractal_pixel_top.sv
bench/testbench.sv
